// ----- src/cip_pkg.sv -----
// ----------------------------------------------------------------------------
// cip_pkg: shared types and constants of the complex integer power block
// Transaction structs, sign-magnitude component types, status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package cip_pkg;

	localparam int CW = 32;   // component width
	localparam int EW = 64;   // exponent width

	localparam logic [CW-1:0] POS_LIM = {1'b0, {(CW-1){1'b1}}};

	localparam logic [1:0] STATUS_EXACT = 2'd0;
	localparam logic [1:0] STATUS_SAT   = 2'd1;
	localparam logic [1:0] STATUS_DIV0  = 2'd2;

	typedef struct packed {
		logic signed [CW-1:0] base_real;
		logic signed [CW-1:0] base_imag;
		logic signed [EW-1:0] exponent;
	} arg_t;

	typedef struct packed {
		logic signed [CW-1:0] power_real;
		logic signed [CW-1:0] power_imag;
		logic        [1:0]    status;
	} res_t;

	typedef struct packed {
		logic          neg;
		logic [CW-1:0] mag;
	} comp_t;

	typedef struct packed {
		comp_t re;
		comp_t im;
	} cplx_t;

endpackage

`default_nettype wire

// ----- src/cip_smul.sv -----
// ----------------------------------------------------------------------------
// cip_smul: bit-serial unsigned multiplier
// Shift-add over the multiplier, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cip_smul #(
	parameter int W = 32
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic [W-1:0]   a,
	input  wire logic [W-1:0]   b,
	output logic                done,
	output logic [2*W-1:0]      prod
);

	localparam int CNTW = $clog2(W + 1);

	logic [W-1:0]    a_q;
	logic [2*W-1:0]  p_q;
	logic [CNTW-1:0] cnt_q;
	logic            done_q;
	logic [W:0]      sum;

	// add the multiplicand into the high half when the low bit is set
	assign sum = {1'b0, p_q[2*W-1:W]} + (p_q[0] ? {1'b0, a_q} : {(W+1){1'b0}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNTW'(W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			p_q <= {{W{1'b0}}, b};
		end else if (cnt_q != '0) begin
			p_q <= {sum, p_q[W-1:1]};
		end
	end

	assign done = done_q;
	assign prod = p_q;

endmodule

`default_nettype wire

// ----- src/cip_div.sv -----
// ----------------------------------------------------------------------------
// cip_div: restoring divider with round to nearest
// One quotient bit per cycle, then a rounding step; quotient bits above
// the kept width fold into an overflow flag.
// ----------------------------------------------------------------------------
`default_nettype none

module cip_div #(
	parameter int NW = 64,
	parameter int DW = 64,
	parameter int QW = 33
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic               done,
	output logic [QW-1:0]      quo,
	output logic               ovf
);

	localparam int CNTW = $clog2(NW + 2);

	logic [NW-1:0]   n_q;
	logic [DW-1:0]   d_q;
	logic [DW-1:0]   r_q;
	logic [QW-1:0]   q_q;
	logic            ovf_q;
	logic [CNTW-1:0] cnt_q;
	logic            done_q;
	logic [DW:0]     r2;
	logic            ge;
	logic [DW:0]     rn;
	logic            inc;
	logic [QW:0]     qr;

	assign r2  = {r_q, n_q[NW-1]};
	assign ge  = r2 >= {1'b0, d_q};
	assign rn  = ge ? r2 - {1'b0, d_q} : r2;
	assign inc = {r_q, 1'b0} >= {1'b0, d_q};
	assign qr  = {1'b0, q_q} + (QW+1)'(inc);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNTW'(NW + 1);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= num;
			d_q   <= den;
			r_q   <= '0;
			q_q   <= '0;
			ovf_q <= 1'b0;
		end else if (cnt_q > CNTW'(1)) begin
			n_q   <= {n_q[NW-2:0], 1'b0};
			r_q   <= rn[DW-1:0];
			q_q   <= {q_q[QW-2:0], ge};
			ovf_q <= ovf_q | q_q[QW-1];
		end else if (cnt_q == CNTW'(1)) begin
			// round half away from zero on the magnitude
			q_q   <= qr[QW-1:0];
			ovf_q <= ovf_q | qr[QW];
		end
	end

	assign done = done_q;
	assign quo  = q_q;
	assign ovf  = ovf_q;

endmodule

`default_nettype wire

// ----- src/complex_integer_power.sv -----
// ----------------------------------------------------------------------------
// complex_integer_power: complex base raised to a signed integer power
// Square-and-multiply over the exponent magnitude with bit-serial complex
// products; negative powers take conj(p)/|p|^2 through serial dividers.
// ----------------------------------------------------------------------------
//
//  channel | valid     | stall     | payload | moves
//  --------+-----------+-----------+---------+------------------------------
//  input   | arg_valid | arg_stall | arg     | base and exponent
//  output  | res_valid | res_stall | res     | power components and status
//
//  Sequence: each complex product passes a start state, the four bit-serial
//  multipliers and two states to round and saturate. A squaring round adds
//  a loop state; up to 63 squarings and 63 accumulate products, plus one |p|^2
//  product and the reciprocal dividers when the exponent is negative, plus
//  accept and load.
//  One transaction at a time: arg_stall is high from acceptance until the
//  result is loaded into the output register.
//  The output register holds a result under res_stall while the next
//  transaction is accepted and computed.
//  Reset clears the control state and the top-level data registers; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_integer_power #(
	parameter int FRACTION_BITS = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          arg_valid,
	output logic               arg_stall,
	input  wire cip_pkg::arg_t arg,
	output logic               res_valid,
	input  wire logic          res_stall,
	output cip_pkg::res_t      res
);

	localparam int CW = cip_pkg::CW;
	localparam int EW = cip_pkg::EW;
	localparam int PW = 2 * CW;           // raw product width
	localparam int MW = PW + 1;           // signed-magnitude sum width
	localparam int NW = CW + 2 * FRACTION_BITS;
	localparam int QW = CW + 1;
	localparam logic [CW-1:0] ONE_MAG = CW'(1) << FRACTION_BITS;
	localparam logic [MW-1:0] HALF    = MW'(1) << (FRACTION_BITS - 1);

	typedef enum logic [3:0] {
		S_IDLE, S_LOOP, S_START, S_MUL, S_FIN1, S_FIN2, S_DSUM, S_DIV, S_RFIN, S_DONE
	} state_t;

	typedef enum logic [1:0] {
		OP_SQ, OP_ACC, OP_DEN
	} op_t;

	typedef struct packed {
		logic          sat;
		cip_pkg::comp_t c;
	} fit_t;

	typedef struct packed {
		logic          neg;
		logic [MW-1:0] mag;
	} wsum_t;

	// saturate a sign-magnitude value to the component range
	function automatic fit_t fit_fn(input logic neg, input logic [MW-1:0] m);
		logic [MW-1:0] lim;
		fit_t f;
		lim = {{(MW-CW){1'b0}}, cip_pkg::POS_LIM} + MW'(neg);
		f.sat   = m > lim;
		f.c.mag = f.sat ? lim[CW-1:0] : m[CW-1:0];
		f.c.neg = neg && (f.c.mag != '0);
		return f;
	endfunction

	// signed-magnitude sum of two raw products
	function automatic wsum_t sum_fn(input logic an, input logic [PW-1:0] a,
		input logic bn, input logic [PW-1:0] b);
		wsum_t s;
		if (an == bn) begin
			s.neg = an;
			s.mag = {1'b0, a} + {1'b0, b};
		end else if (a >= b) begin
			s.neg = an;
			s.mag = {1'b0, a - b};
		end else begin
			s.neg = bn;
			s.mag = {1'b0, b - a};
		end
		return s;
	endfunction

	function automatic cip_pkg::comp_t decode_fn(input logic [CW-1:0] raw);
		cip_pkg::comp_t c;
		c.neg = raw[CW-1];
		c.mag = raw[CW-1] ? (~raw + 1'b1) : raw;
		return c;
	endfunction

	function automatic logic [CW-1:0] encode_fn(input cip_pkg::comp_t c);
		return c.neg ? (~c.mag + 1'b1) : c.mag;
	endfunction

	state_t         state_q;
	op_t            op_q;
	cip_pkg::cplx_t z_q;
	cip_pkg::cplx_t acc_q;
	logic [EW-1:0]  e_q;
	logic           eneg_q;
	logic           sat_q;
	logic           div0_q;
	logic [3:0]     sgn_q;     // product signs, the subtraction folded in
	wsum_t          sre_q;
	wsum_t          sim_q;
	logic           res_valid_q;
	cip_pkg::res_t  res_q;

	cip_pkg::cplx_t x, y;
	logic           mul_start;
	logic [3:0]     mul_done;
	logic [PW-1:0]  prod [4];
	logic           div_start;
	logic           div_re_done, div_im_done;
	logic [QW-1:0]  quo_re, quo_im;
	logic           ovf_re, ovf_im;
	logic [PW-1:0]  den;
	logic [NW-1:0]  num_re, num_im;
	fit_t           fre, fim, qre, qim;
	logic           out_load;
	cip_pkg::comp_t in_re, in_im;
	logic           in_eneg;
	logic [EW-1:0]  in_emag;

	// operand select: square z, multiply acc by z, or |acc|^2
	assign x = (op_q == OP_SQ)  ? z_q   : acc_q;
	assign y = (op_q == OP_DEN) ? acc_q : z_q;

	assign mul_start = state_q == S_START;
	assign div_start = state_q == S_DSUM;

	cip_smul #(.W(CW)) u_mul_rr (
		.clk, .arst_n, .start(mul_start), .a(x.re.mag), .b(y.re.mag),
		.done(mul_done[0]), .prod(prod[0]));
	cip_smul #(.W(CW)) u_mul_ii (
		.clk, .arst_n, .start(mul_start), .a(x.im.mag), .b(y.im.mag),
		.done(mul_done[1]), .prod(prod[1]));
	cip_smul #(.W(CW)) u_mul_ri (
		.clk, .arst_n, .start(mul_start), .a(x.re.mag), .b(y.im.mag),
		.done(mul_done[2]), .prod(prod[2]));
	cip_smul #(.W(CW)) u_mul_ir (
		.clk, .arst_n, .start(mul_start), .a(x.im.mag), .b(y.re.mag),
		.done(mul_done[3]), .prod(prod[3]));

	// |p|^2 stays exact; it fits PW bits since each square is at most 2^(2CW-2)
	assign den    = prod[0] + prod[1];
	assign num_re = {acc_q.re.mag, {(2*FRACTION_BITS){1'b0}}};
	assign num_im = {acc_q.im.mag, {(2*FRACTION_BITS){1'b0}}};

	cip_div #(.NW(NW), .DW(PW), .QW(QW)) u_div_re (
		.clk, .arst_n, .start(div_start), .num(num_re), .den(den),
		.done(div_re_done), .quo(quo_re), .ovf(ovf_re));
	cip_div #(.NW(NW), .DW(PW), .QW(QW)) u_div_im (
		.clk, .arst_n, .start(div_start), .num(num_im), .den(den),
		.done(div_im_done), .quo(quo_im), .ovf(ovf_im));

	// round the sums, then saturate them and the divider quotients
	assign fre = fit_fn(sre_q.neg, (sre_q.mag + HALF) >> FRACTION_BITS);
	assign fim = fit_fn(sim_q.neg, (sim_q.mag + HALF) >> FRACTION_BITS);
	assign qre = fit_fn(acc_q.re.neg,
		ovf_re ? {MW{1'b1}} : {{(MW-QW){1'b0}}, quo_re});
	assign qim = fit_fn(!acc_q.im.neg,
		ovf_im ? {MW{1'b1}} : {{(MW-QW){1'b0}}, quo_im});

	assign in_re   = decode_fn(arg.base_real);
	assign in_im   = decode_fn(arg.base_imag);
	assign in_eneg = arg.exponent[EW-1];
	assign in_emag = in_eneg ? (~arg.exponent + 1'b1) : arg.exponent;

	assign out_load = (state_q == S_DONE) && (!res_valid_q || !res_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_SQ;
			res_valid_q <= 1'b0;
			sat_q       <= 1'b0;
			div0_q      <= 1'b0;
			eneg_q      <= 1'b0;
			e_q         <= '0;
			z_q         <= '0;
			acc_q       <= '0;
			sgn_q       <= '0;
			sre_q       <= '0;
			sim_q       <= '0;
			res_q       <= '0;
		end else begin
			// drop the held result once it is taken and no new one replaces it
			if (res_valid_q && !res_stall && !out_load) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (arg_valid) begin
						z_q.re <= in_re;
						z_q.im <= in_im;
						if (in_emag[0]) begin
							acc_q.re <= in_re;
							acc_q.im <= in_im;
						end else begin
							acc_q.re <= '{neg: 1'b0, mag: ONE_MAG};
							acc_q.im <= '0;
						end
						e_q     <= in_emag >> 1;
						eneg_q  <= in_eneg;
						sat_q   <= 1'b0;
						div0_q  <= 1'b0;
						state_q <= S_LOOP;
					end
				end
				S_LOOP: begin
					if (e_q != '0) begin
						op_q    <= OP_SQ;
						state_q <= S_START;
					end else if (!eneg_q) begin
						state_q <= S_DONE;
					end else if (acc_q.re.mag == '0 && acc_q.im.mag == '0) begin
						div0_q  <= 1'b1;
						state_q <= S_DONE;
					end else begin
						op_q    <= OP_DEN;
						state_q <= S_START;
					end
				end
				S_START: begin
					// latch the signs of ac, bd (negated), ad, bc
					sgn_q   <= {x.im.neg ^ y.re.neg, x.re.neg ^ y.im.neg,
						!(x.im.neg ^ y.im.neg), x.re.neg ^ y.re.neg};
					state_q <= S_MUL;
				end
				S_MUL: begin
					if (mul_done[0]) begin
						state_q <= (op_q == OP_DEN) ? S_DSUM : S_FIN1;
					end
				end
				S_FIN1: begin
					sre_q   <= sum_fn(sgn_q[0], prod[0], sgn_q[1], prod[1]);
					sim_q   <= sum_fn(sgn_q[2], prod[2], sgn_q[3], prod[3]);
					state_q <= S_FIN2;
				end
				S_FIN2: begin
					sat_q <= sat_q | fre.sat | fim.sat;
					if (op_q == OP_SQ) begin
						z_q.re <= fre.c;
						z_q.im <= fim.c;
						if (e_q[0]) begin
							op_q    <= OP_ACC;
							state_q <= S_START;
						end else begin
							e_q     <= e_q >> 1;
							state_q <= S_LOOP;
						end
					end else begin
						acc_q.re <= fre.c;
						acc_q.im <= fim.c;
						e_q      <= e_q >> 1;
						state_q  <= S_LOOP;
					end
				end
				S_DSUM: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_re_done) begin
						state_q <= S_RFIN;
					end
				end
				S_RFIN: begin
					acc_q.re <= qre.c;
					acc_q.im <= qim.c;
					sat_q    <= sat_q | qre.sat | qim.sat;
					state_q  <= S_DONE;
				end
				S_DONE: begin
					// hold until the output register is free
					if (out_load) begin
						res_valid_q <= 1'b1;
						if (div0_q) begin
							res_q.power_real <= cip_pkg::POS_LIM;
							res_q.power_imag <= cip_pkg::POS_LIM;
							res_q.status     <= cip_pkg::STATUS_DIV0;
						end else begin
							res_q.power_real <= encode_fn(acc_q.re);
							res_q.power_imag <= encode_fn(acc_q.im);
							res_q.status     <= sat_q ? cip_pkg::STATUS_SAT
								: cip_pkg::STATUS_EXACT;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// both dividers and all multipliers run in lockstep; their done flags mirror
	logic unused_done;
	assign unused_done = ^{mul_done[3:1], div_im_done};

	assign arg_stall = (state_q != S_IDLE) || unused_done & 1'b0;
	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire

// ----- src/cip_checker.sv -----
// ----------------------------------------------------------------------------
// cip_checker: port-level assertions for complex_integer_power
// Watches the two channels and the result codes; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cip_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          arg_valid,
	input wire logic          arg_stall,
	input wire cip_pkg::arg_t arg,
	input wire logic          res_valid,
	input wire logic          res_stall,
	input wire cip_pkg::res_t res
);

	// a held result stays put until taken
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	// one transaction at a time: the input closes right after acceptance
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		arg_valid && !arg_stall |=> arg_stall)
		else $error("input open right after acceptance");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.status == cip_pkg::STATUS_EXACT
			|| res.status == cip_pkg::STATUS_SAT
			|| res.status == cip_pkg::STATUS_DIV0)
		else $error("undefined status code");

	// reciprocal of zero saturates both components positive
	a_div0: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status == cip_pkg::STATUS_DIV0 |->
			res.power_real == cip_pkg::POS_LIM && res.power_imag == cip_pkg::POS_LIM)
		else $error("zero reciprocal without saturated components");

endmodule

bind complex_integer_power cip_checker u_cip_checker (.*);

`default_nettype wire
